### rtl/core/averaged_temperature_hysteresis_switch_defines.svh
// ----------------------------------------------------------------------------
// averaged temperature hysteresis switch: assertion macros
// shared checking shorthands, clocked on clk_i; the first is disabled in the active-low reset
// ----------------------------------------------------------------------------
`ifndef AVERAGED_TEMPERATURE_HYSTERESIS_SWITCH_DEFINES_SVH
`define AVERAGED_TEMPERATURE_HYSTERESIS_SWITCH_DEFINES_SVH

// checked only out of reset
`define ATHSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define ATHSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/athsw_pkg.sv
// ----------------------------------------------------------------------------
// athsw_pkg
// constants, types and register codes of the averaged temperature switch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package athsw_pkg;

  localparam int unsigned NSamples = 10;

  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 14;
  localparam int unsigned ThrW    = 13;
  localparam int unsigned TempW   = 13;
  localparam int unsigned VoltW   = 6;
  localparam int unsigned CntW    = (NSamples > 1) ? $clog2(NSamples) : 1;

  // average in tenths is (50*sum - 27315*n) / (10*n)
  localparam int unsigned TempOffs = 27315 * NSamples;
  localparam int unsigned TempDen  = 10 * NSamples;
  localparam int unsigned VoltDen  = 20 * NSamples;
  localparam int unsigned NumW     = $clog2(50 * 1023 * NSamples + 1) + 1;

  // reciprocal multiply gives the quotient or one less
  localparam int unsigned RecipShift = 24;
  localparam int unsigned TempRecip  = (1 << RecipShift) / TempDen;
  localparam int unsigned VoltRecip  = (1 << RecipShift) / VoltDen;

  localparam int unsigned ThrProdW = ThrW + $clog2(TempDen + 1);
  localparam int unsigned CmpW     = ((NumW > ThrProdW) ? NumW : ThrProdW) + 1;

  localparam int unsigned MidDepth  = 4;
  localparam int unsigned MidPtrW   = $clog2(MidDepth);
  localparam int unsigned MidCntW   = $clog2(MidDepth + 1);
  localparam int unsigned OutDepth  = 4;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned OutCntW   = $clog2(OutDepth + 1);

  localparam int unsigned RegIdxW   = 1;
  localparam logic [RegIdxW-1:0] RegFanOn  = 1'b0;
  localparam logic [RegIdxW-1:0] RegFanOff = 1'b1;

  localparam logic signed [ThrW-1:0] FanOnRst  = 13'sd197;
  localparam logic signed [ThrW-1:0] FanOffRst = 13'sd191;

  typedef struct packed {
    logic signed [ThrW-1:0] on_thr;
    logic signed [ThrW-1:0] off_thr;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [VoltW-1:0] volt;
    logic             fan;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/athsw_queue.sv
// ----------------------------------------------------------------------------
// athsw_queue
// short fifo of finished block sums between accumulator and arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module athsw_queue
  import athsw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [SumW-1:0] wdata_i,
  input  wire logic            pop_i,
  output logic      [SumW-1:0] rdata_o,
  output q_stat_t              stat_o
);

  logic [SumW-1:0]    mem_q [MidDepth];
  logic [MidPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [MidPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [MidCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == MidCntW'(MidDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + MidPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + MidPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + MidCntW'(do_push) - MidCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/athsw_front.sv
// ----------------------------------------------------------------------------
// athsw_front
// sample accumulator: sums one block of samples and hands the sum on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module athsw_front
  import athsw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [SampleW-1:0] adc_sample_i,
  input  wire q_stat_t            mid_stat_i,
  output logic                    mid_push_o,
  output logic      [SumW-1:0]    mid_sum_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            accept;
  logic            last;

  assign full       = mid_stat_i.full;
  assign accept     = push && !full;
  assign last       = (cnt_q == CntW'(NSamples - 1));
  assign mid_sum_o  = sum_q + SumW'(adc_sample_i);
  assign mid_push_o = accept && last;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (accept) begin
      if (last) begin
        cnt_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        sum_d = mid_sum_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/athsw_back.sv
// ----------------------------------------------------------------------------
// athsw_back
// block arithmetic: averages, hysteresis flag and the result fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module athsw_back
  import athsw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire q_stat_t          mid_stat_i,
  input  wire logic [SumW-1:0]  mid_sum_i,
  output logic                  mid_pop_o,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [TempW-1:0] temp_tenths_o,
  output logic      [VoltW-1:0] volt_tenths_o,
  output logic                  fan_on_o
);

  localparam int unsigned TProdW = NumW + RecipShift;
  localparam int unsigned VProdW = SumW + RecipShift;

  // stage 1: numerator, magnitude, threshold tests
  logic signed [NumW-1:0] num_c;
  logic        [NumW-1:0] abs_c;
  logic signed [CmpW-1:0] num_ext, on_lim, off_lim;
  logic                   v1_q;
  logic        [NumW-1:0] abs1_q;
  logic        [SumW-1:0] sum1_q;
  logic                   neg1_q, on1_q, off1_q;

  // stage 2: reciprocal estimates
  logic [TProdW-1:0]      tprod;
  logic [VProdW-1:0]      vprod;
  logic                   v2_q;
  logic [NumW-1:0]        abs2_q, tq0_q;
  logic [SumW-1:0]        sum2_q, vq0_q;
  logic                   neg2_q, on2_q, off2_q;

  // final correction
  logic [NumW-1:0]        trem, tq, tsgn;
  logic [SumW-1:0]        vrem, vq;
  logic                   fan_q, fan_d;
  result_t                res;

  // result fifo
  result_t                omem_q [OutDepth];
  logic [OutPtrW-1:0]     owr_q, ord_q;
  logic [OutCntW-1:0]     ocnt_q, ocnt_d;
  logic [OutCntW:0]       occ;
  logic                   opop;

  assign num_c = $signed(NumW'(mid_sum_i) * NumW'(50) - NumW'(TempOffs));
  assign abs_c = num_c[NumW-1] ? NumW'(-num_c) : NumW'(num_c);

  assign num_ext = CmpW'(num_c);
  assign on_lim  = CmpW'(cfg_i.on_thr) * $signed(CmpW'(TempDen));
  assign off_lim = CmpW'(cfg_i.off_thr) * $signed(CmpW'(TempDen));

  // credit check: fifo entries plus transactions still in the pipe
  assign occ       = (OutCntW + 1)'(ocnt_q) + (OutCntW + 1)'(v1_q) + (OutCntW + 1)'(v2_q);
  assign mid_pop_o = !mid_stat_i.empty && (occ < (OutCntW + 1)'(OutDepth));

  assign tprod = TProdW'(abs1_q) * TProdW'(TempRecip);
  assign vprod = VProdW'(sum1_q) * VProdW'(VoltRecip);

  always_comb begin
    trem = abs2_q - NumW'(tq0_q * NumW'(TempDen));
    tq   = tq0_q + NumW'(trem >= NumW'(TempDen));
    tsgn = neg2_q ? NumW'(-tq) : tq;
    vrem = sum2_q - SumW'(vq0_q * SumW'(VoltDen));
    vq   = vq0_q + SumW'(vrem >= SumW'(VoltDen));
    // on test wins when both thresholds are crossed
    priority if (on2_q) begin
      fan_d = 1'b1;
    end else if (off2_q) begin
      fan_d = 1'b0;
    end else begin
      fan_d = fan_q;
    end
    res.temp = tsgn[TempW-1:0];
    res.volt = vq[VoltW-1:0];
    res.fan  = fan_d;
  end

  always_ff @(posedge clk_i) begin
    abs1_q <= abs_c;
    sum1_q <= mid_sum_i;
    neg1_q <= num_c[NumW-1];
    on1_q  <= num_ext > on_lim;
    off1_q <= num_ext < off_lim;
    abs2_q <= abs1_q;
    sum2_q <= sum1_q;
    neg2_q <= neg1_q;
    on2_q  <= on1_q;
    off2_q <= off1_q;
    tq0_q  <= tprod[RecipShift +: NumW];
    vq0_q  <= vprod[RecipShift +: SumW];
    if (v2_q) begin
      omem_q[owr_q] <= res;
    end
  end

  assign empty         = (ocnt_q == '0);
  assign opop          = pop && !empty;
  assign temp_tenths_o = omem_q[ord_q].temp;
  assign volt_tenths_o = omem_q[ord_q].volt;
  assign fan_on_o      = omem_q[ord_q].fan;
  assign ocnt_d        = ocnt_q + OutCntW'(v2_q) - OutCntW'(opop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      fan_q  <= 1'b0;
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      v1_q   <= mid_pop_o;
      v2_q   <= v1_q;
      ocnt_q <= ocnt_d;
      if (v2_q) begin
        fan_q <= fan_d;
        owr_q <= owr_q + OutPtrW'(1);
      end
      if (opop) begin
        ord_q <= ord_q + OutPtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/averaged_temperature_hysteresis_switch.sv
// ----------------------------------------------------------------------------
// averaged_temperature_hysteresis_switch
// block average of converter samples with a hysteresis fan flag
// ----------------------------------------------------------------------------
// a result passes the sum queue and both arithmetic stages into the result fifo before it shows on the outputs
// throughput: one sample per cycle while the sum queue is not full, set by the accumulator
// the arithmetic is a two-stage pipe behind a 4-entry sum queue, results leave a 4-entry fifo
// reset: sum, count and fan flag clear, queues empty, thresholds return to 197 and 191
`timescale 1ns / 1ps
`default_nettype none
`include "averaged_temperature_hysteresis_switch_defines.svh"

module averaged_temperature_hysteresis_switch
  import athsw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [ThrW-1:0]    cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [SampleW-1:0] adc_sample_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [TempW-1:0]   temp_tenths_o,
  output logic      [VoltW-1:0]   volt_tenths_o,
  output logic                    fan_on_o
);

  cfg_t            cfg_q;
  q_stat_t         mid_stat;
  logic            mid_push, mid_pop;
  logic [SumW-1:0] mid_wsum, mid_rsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr  <= FanOnRst;
      cfg_q.off_thr <= FanOffRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFanOn:  cfg_q.on_thr  <= $signed(cfg_wdata_i);
        RegFanOff: cfg_q.off_thr <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  athsw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .adc_sample_i (adc_sample_i),
    .mid_stat_i   (mid_stat),
    .mid_push_o   (mid_push),
    .mid_sum_o    (mid_wsum)
  );

  athsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wsum),
    .pop_i   (mid_pop),
    .rdata_o (mid_rsum),
    .stat_o  (mid_stat)
  );

  athsw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .mid_stat_i    (mid_stat),
    .mid_sum_i     (mid_rsum),
    .mid_pop_o     (mid_pop),
    .pop           (pop),
    .empty         (empty),
    .temp_tenths_o (temp_tenths_o),
    .volt_tenths_o (volt_tenths_o),
    .fan_on_o      (fan_on_o)
  );

  // a finished block sum is never offered to a full queue
  `ATHSW_ASSERT(a_mid_push_room, mid_push |-> !mid_stat.full, "block sum pushed into full queue")
  // the arithmetic only draws sums that are there
  `ATHSW_ASSERT(a_mid_pop_avail, mid_pop |-> !mid_stat.empty, "sum queue popped while empty")
  // a waiting result only leaves through a pop transaction
  `ATHSW_ASSERT(a_result_kept, (!empty && !pop) |=> !empty, "waiting result lost")
  // mid queue never claims to be full and empty at once
  `ATHSW_ASSERT(a_mid_stat, !(mid_stat.full && mid_stat.empty), "queue full and empty")

endmodule

`default_nettype wire
